@@ sv/ima4_pkg.sv @@
// shared constants, status type, step table and index adjust function for the ima4 block decoder
`timescale 1ns / 1ps

package ima4_pkg;

  localparam logic [5:0] BLOCK_BYTES  = 6'd34;
  localparam logic [6:0] FRAMES       = 7'd64;
  localparam logic [3:0] MAX_CHANNELS = 4'd2;
  localparam logic [6:0] MAX_INDEX    = 7'd88;
  localparam logic [5:0] POS_HDR_HI   = 6'd0;
  localparam logic [5:0] POS_HDR_LO   = 6'd1;
  localparam logic [5:0] POS_DATA     = 6'd2;
  localparam logic [1:0] CHAN_RESET   = 2'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_INDEX   = 2'd1,
    ST_BAD_CHANNEL = 2'd2
  } status_t;

  localparam logic [14:0] STEP_TABLE [89] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    unique case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

@@ sv/ima4_nibble_dec.sv @@
// one adpcm code: step lookup, delta build, saturating predictor add, index clamp
`timescale 1ns / 1ps

module ima4_nibble_dec
  import ima4_pkg::*;
(
  input  logic signed [15:0] pred_in,
  input  logic        [6:0]  idx_in,
  input  logic        [3:0]  code,
  output logic signed [15:0] pred_out,
  output logic        [6:0]  idx_out
);

  logic        [6:0]  idx_c;
  logic        [14:0] step;
  logic        [16:0] delta;
  logic signed [17:0] p_sum;
  logic signed [7:0]  ni;

  always_comb begin
    idx_c = (idx_in > MAX_INDEX) ? MAX_INDEX : idx_in;
    step  = STEP_TABLE[idx_c];
    delta = {5'd0, step[14:3]};
    if (code[2]) delta = delta + {2'd0, step};
    if (code[1]) delta = delta + {3'd0, step[14:1]};
    if (code[0]) delta = delta + {4'd0, step[14:2]};
    if (code[3]) begin
      p_sum = {{2{pred_in[15]}}, pred_in} - $signed({1'b0, delta});
    end else begin
      p_sum = {{2{pred_in[15]}}, pred_in} + $signed({1'b0, delta});
    end
    if (p_sum < -18'sd32768) begin
      pred_out = -16'sd32768;
    end else if (p_sum > 18'sd32767) begin
      pred_out = 16'sd32767;
    end else begin
      pred_out = p_sum[15:0];
    end
    ni = $signed({1'b0, idx_c}) + 8'(index_adjust(code[2:0]));
    if (ni < 8'sd0) begin
      idx_out = 7'd0;
    end else if (ni > $signed({1'b0, MAX_INDEX})) begin
      idx_out = MAX_INDEX;
    end else begin
      idx_out = ni[6:0];
    end
  end

endmodule

@@ sv/ima4_adpcm_block_decoder.sv @@
// top level of the ima4 adpcm block decoder
`timescale 1ns / 1ps

// Bytes of a 34-byte ima4 channel block enter one per transfer, tagged with
// channel and position. A byte waits in an input register and is worked off
// against the per-channel predictor and step index; samples leave through a
// registered output. A decoded data byte holds the input register while its
// two codes pass one per cycle, unless the output stalls, through a single decode
// adder, since the second code needs the predictor the first one leaves.
// A byte is taken while the previous result still waits at the output.
// Errors (step index above 88, channel at or above the configured count)
// give one result with last set and suppress the block's samples.
module ima4_adpcm_block_decoder
  import ima4_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               channel,
  input  logic [5:0]         byte_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic               channel_out,
  output logic [5:0]         frame_index,
  output logic               last,
  output logic [1:0]         status
);

  logic [1:0]         chan_count;
  logic signed [15:0] pred_store [2];
  logic [6:0]         idx_store [2];
  logic [7:0]         hdr_hi;
  logic               block_bad;

  logic               s1_valid;
  logic               s1_phase;
  logic [7:0]         s1_byte;
  logic               s1_ch;
  logic [5:0]         s1_pos;

  logic               accept;
  logic               out_free;
  logic               proceed;
  logic               emit;
  logic               finish;
  logic               ch_ok;
  logic [15:0]        hdr;
  logic [6:0]         hdr_idx;
  logic signed [15:0] hdr_pred;
  logic signed [16:0] diff;
  logic [6:0]         frame;
  logic [6:0]         frame_nxt;
  logic [3:0]         code;
  logic signed [15:0] pred_cur;
  logic [6:0]         idx_cur;
  logic signed [15:0] pred_dec;
  logic [6:0]         idx_dec;
  logic               st_wr;
  logic signed [15:0] st_pred;
  logic [6:0]         st_idx;
  logic               hdr_wr;
  logic               bad_wr;
  logic               bad_val;
  logic signed [15:0] res_sample;
  logic [5:0]         res_frame;
  logic               res_last;
  status_t            res_status;

  assign cfg_ready = 1'b1;

  assign pred_cur = pred_store[s1_ch];
  assign idx_cur  = idx_store[s1_ch];
  assign code     = s1_phase ? s1_byte[7:4] : s1_byte[3:0];

  ima4_nibble_dec u_dec (
    .pred_in  (pred_cur),
    .idx_in   (idx_cur),
    .code     (code),
    .pred_out (pred_dec),
    .idx_out  (idx_dec)
  );

  always_comb begin
    ch_ok      = ({1'b0, s1_ch} < chan_count) && ({3'd0, s1_ch} < MAX_CHANNELS);
    hdr        = {hdr_hi, s1_byte};
    hdr_idx    = hdr[6:0];
    hdr_pred   = {hdr[15:7], 7'd0};
    diff       = {hdr_pred[15], hdr_pred} - {pred_cur[15], pred_cur};
    frame      = {s1_pos - POS_DATA, s1_phase};
    frame_nxt  = frame + 7'd1;
    emit       = 1'b0;
    finish     = 1'b1;
    st_wr      = 1'b0;
    st_pred    = pred_dec;
    st_idx     = idx_dec;
    hdr_wr     = 1'b0;
    bad_wr     = 1'b0;
    bad_val    = 1'b0;
    res_sample = 16'sd0;
    res_frame  = 6'd0;
    res_last   = 1'b1;
    res_status = ST_OK;
    if (s1_pos >= BLOCK_BYTES) begin
      finish = 1'b1;
    end else if (s1_pos == POS_HDR_HI) begin
      hdr_wr = 1'b1;
    end else if (s1_pos == POS_HDR_LO) begin
      bad_wr = 1'b1;
      if (!ch_ok) begin
        bad_val    = 1'b1;
        emit       = 1'b1;
        res_status = ST_BAD_CHANNEL;
      end else if (hdr_idx > MAX_INDEX) begin
        bad_val    = 1'b1;
        emit       = 1'b1;
        res_status = ST_BAD_INDEX;
      end else if (hdr_idx != idx_cur || diff > 17'sd127 || diff < -17'sd127) begin
        st_wr   = 1'b1;
        st_pred = hdr_pred;
        st_idx  = hdr_idx;
      end
    end else if (ch_ok && !block_bad && frame < FRAMES) begin
      emit       = 1'b1;
      st_wr      = 1'b1;
      res_sample = pred_dec;
      res_frame  = frame[5:0];
      res_last   = (frame_nxt == FRAMES);
      finish     = s1_phase || (frame_nxt >= FRAMES);
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign proceed  = !emit || out_free;
  assign in_stall = s1_valid && !(proceed && finish);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= CHAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chan_count <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_phase <= 1'b0;
    end else if (s1_valid && proceed) begin
      s1_valid <= !finish;
      s1_phase <= !finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= data_byte;
      s1_ch   <= channel;
      s1_pos  <= byte_pos;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      pred_store[0] <= 16'sd0;
      pred_store[1] <= 16'sd0;
      idx_store[0]  <= 7'd0;
      idx_store[1]  <= 7'd0;
      hdr_hi        <= 8'd0;
      block_bad     <= 1'b0;
    end else if (s1_valid && proceed) begin
      if (st_wr) begin
        pred_store[s1_ch] <= st_pred;
        idx_store[s1_ch]  <= st_idx;
      end
      if (hdr_wr) begin
        hdr_hi <= s1_byte;
      end
      if (bad_wr) begin
        block_bad <= bad_val;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && emit && proceed) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && emit && proceed) begin
      sample      <= res_sample;
      channel_out <= s1_ch;
      frame_index <= res_frame;
      last        <= res_last;
      status      <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx_store[0] <= MAX_INDEX && idx_store[1] <= MAX_INDEX)
    else $error("step index store above range");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && sample == 16'sd0 && frame_index == 6'd0)
    else $error("error result with wrong fields");

  a_second_nibble: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_phase && !$past(s1_phase) |-> $past(s1_valid && proceed))
    else $error("second code without first");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("stall with empty input register");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    s1_valid && emit && proceed |=> out_valid)
    else $error("result lost");
`endif

endmodule

@@ sim/ima4_decoder_checker.sv @@
// checker for the ima4 block decoder: tracks channel state, predicts and compares samples
`timescale 1ns / 1ps

module ima4_decoder_checker
  import ima4_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               channel,
  input  logic [5:0]         byte_pos,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] sample,
  input  logic               channel_out,
  input  logic [5:0]         frame_index,
  input  logic               last,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 checked,
  output int                 flagged
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic [5:0]         frame;
    logic               last;
    status_t            status;
  } pcm_result_t;

  pcm_result_t        expected_samples[$];
  logic [1:0]         chan_count;
  logic signed [15:0] pred_st [MAX_CHANNELS];
  logic [6:0]         idx_st [MAX_CHANNELS];
  logic [7:0]         hdr_hi;
  logic               block_bad;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    flagged    = 0;
  end

  function automatic logic signed [15:0] decode_nibble(input logic ch, input logic [3:0] code);
    int         step;
    int         delta;
    int         p;
    int         ni;
    logic [6:0] idx;
    idx   = (idx_st[ch] > MAX_INDEX) ? MAX_INDEX : idx_st[ch];
    step  = int'(STEP_TABLE[idx]);
    delta = step >>> 3;
    if (code[2]) delta += step;
    if (code[1]) delta += step >>> 1;
    if (code[0]) delta += step >>> 2;
    p = int'(pred_st[ch]) + (code[3] ? -delta : delta);
    if (p < -32768) p = -32768;
    if (p > 32767) p = 32767;
    pred_st[ch] = p[15:0];
    ni = int'(idx) + (code[2] ? 2 * int'(code[1:0]) + 2 : -1);
    if (ni < 0) ni = 0;
    if (ni > int'(MAX_INDEX)) ni = int'(MAX_INDEX);
    idx_st[ch] = ni[6:0];
    return p[15:0];
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic ch, input logic [5:0] pos);
    logic [15:0]        header;
    logic [6:0]         idx;
    logic signed [15:0] hpred;
    int                 diff;
    int                 fr;
    int                 k;
    logic               ch_ok;
    pcm_result_t        r;
    ch_ok = (ch < chan_count) && (ch < MAX_CHANNELS);
    if (pos >= BLOCK_BYTES) return;
    if (pos == POS_HDR_HI) begin
      hdr_hi = b;
      return;
    end
    if (pos == POS_HDR_LO) begin
      header = {hdr_hi, b};
      idx    = header[6:0];
      hpred  = {header[15:7], 7'b0};
      if (!ch_ok || idx > MAX_INDEX) begin
        block_bad = 1'b1;
        r.sample  = '0;
        r.channel = ch;
        r.frame   = '0;
        r.last    = 1'b1;
        r.status  = ch_ok ? ST_BAD_INDEX : ST_BAD_CHANNEL;
        expected_samples.push_back(r);
        return;
      end
      block_bad = 1'b0;
      diff = int'(hpred) - int'(pred_st[ch]);
      if (diff < 0) diff = -diff;
      if (idx != idx_st[ch] || diff > 127) begin
        pred_st[ch] = hpred;
        idx_st[ch]  = idx;
      end
      return;
    end
    if (!ch_ok || block_bad) return;
    for (k = 0; k < 2; k++) begin
      fr = 2 * (int'(pos) - int'(POS_DATA)) + k;
      if (fr >= int'(FRAMES)) break;
      r.sample  = decode_nibble(ch, b[4*k +: 4]);
      r.channel = ch;
      r.frame   = fr[5:0];
      r.last    = (fr == int'(FRAMES) - 1);
      r.status  = ST_OK;
      expected_samples.push_back(r);
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pcm_result_t want;
    if (rst) begin
      chan_count = CHAN_RESET;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        pred_st[i] = '0;
        idx_st[i]  = '0;
      end
      hdr_hi    = '0;
      block_bad = 1'b0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample %0d on channel %0d frame %0d", sample, channel_out,
                 frame_index);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          check_field("sample", int'(want.sample), int'(sample));
          check_field("channel_out", int'(want.channel), int'(channel_out));
          check_field("frame_index", int'(want.frame), int'(frame_index));
          check_field("last", int'(want.last), int'(last));
          check_field("status", int'(want.status), int'(status));
          checked++;
          if (want.status != ST_OK) flagged++;
        end
      end
      if (cfg_valid && cfg_ready) chan_count = cfg_data;
      if (in_valid && !in_stall) predict_byte(data_byte, channel, byte_pos);
    end
    pending <= expected_samples.size();
  end

endmodule

@@ sim/tb_ima4_adpcm_block_decoder.sv @@
// testbench top for the ima4 block decoder: clock, reset, byte and config stimulus, verdict
`timescale 1ns / 1ps

module tb_ima4_adpcm_block_decoder;
  import ima4_pkg::*;

  localparam int LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = '0;
  logic               channel = 1'b0;
  logic [5:0]         byte_pos = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample;
  logic               channel_out;
  logic [5:0]         frame_index;
  logic               last;
  logic [1:0]         status;

  int fail_count;
  int pending;
  int checked;
  int flagged;
  int fed = 0;
  int phase = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always #10 clk = ~clk;

  ima4_adpcm_block_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .channel     (channel),
    .byte_pos    (byte_pos),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .channel_out (channel_out),
    .frame_index (frame_index),
    .last        (last),
    .status      (status)
  );

  ima4_decoder_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .channel     (channel),
    .byte_pos    (byte_pos),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .channel_out (channel_out),
    .frame_index (frame_index),
    .last        (last),
    .status      (status),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .flagged     (flagged)
  );

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // sample receiver with random stalls
  initial begin
    int n;
    forever begin
      n = steady ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic ch, input logic [5:0] pos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    channel   <= ch;
    byte_pos  <= pos;
    do @(posedge clk); while (in_stall);
    if (pos < BLOCK_BYTES) fed++;
  endtask

  // hold off until every expected sample is back and the pipe has settled
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_channels(input logic [1:0] count);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [1:0]  first_counts [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
    logic [1:0]  cc;
    logic        ch;
    logic [6:0]  idx;
    logic [15:0] hdr;
    int          nbytes;
    int          r;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: mono after reset
    put_byte(8'hF7, 1'b0, 6'd2);           // data before any header
    put_byte(8'h80, 1'b0, POS_HDR_HI);
    put_byte(8'h00, 1'b0, POS_HDR_LO);     // most negative predictor, index 0
    put_byte(8'hFF, 1'b0, 6'd3);           // saturate low
    put_byte(8'h7F, 1'b0, POS_HDR_HI);
    put_byte(8'hD8, 1'b0, POS_HDR_LO);     // index 88
    put_byte(8'h77, 1'b0, 6'd4);           // saturate high
    put_byte(8'h7F, 1'b0, POS_HDR_HI);
    put_byte(8'hD8, 1'b0, POS_HDR_LO);     // predictor within 127, no reload
    put_byte(8'h08, 1'b0, 6'd5);
    put_byte(8'h7F, 1'b0, POS_HDR_HI);
    put_byte(8'h58, 1'b0, POS_HDR_LO);
    put_byte(8'h00, 1'b0, 6'd33);          // final frame
    put_byte(8'h12, 1'b0, POS_HDR_HI);
    put_byte(8'h59, 1'b0, POS_HDR_LO);     // index 89
    put_byte(8'hAB, 1'b0, 6'd6);           // suppressed
    put_byte(8'hFF, 1'b0, POS_HDR_LO);     // index 127
    put_byte(8'h00, 1'b1, POS_HDR_HI);
    put_byte(8'h10, 1'b1, POS_HDR_LO);     // channel out of range
    put_byte(8'h5A, 1'b1, 6'd7);
    put_byte(8'hFF, 1'b0, BLOCK_BYTES);    // beyond block
    put_byte(8'hFF, 1'b1, 6'd63);
    put_byte(8'h00, 1'b0, POS_HDR_HI);
    put_byte(8'h00, 1'b0, POS_HDR_LO);
    put_byte(8'h3C, 1'b0, POS_DATA);

    // random blocks over changing channel counts
    while (fed < 1500) begin
      wait_quiet();
      if (phase < 4) begin
        cc = first_counts[phase];
      end else begin
        r  = $urandom_range(0, 9);
        cc = (r == 0) ? 2'd0 : (r == 1) ? 2'd3 : (r < 6) ? 2'd2 : 2'd1;
      end
      set_channels(cc);
      phase++;
      repeat ($urandom_range(2, 6)) begin
        steady = ($urandom_range(0, 3) == 0);
        ch  = (cc == 2'd1) ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
        idx = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(89, 127))
                                           : 7'($urandom_range(0, 88));
        hdr = {9'($urandom), idx};
        if (cc == 2'd0) nbytes = $urandom_range(0, 3);
        else nbytes = ($urandom_range(0, 9) < 7) ? 32 : $urandom_range(0, 31);
        put_byte(hdr[15:8], ch, POS_HDR_HI);
        put_byte(hdr[7:0], ch, POS_HDR_LO);
        if ($urandom_range(0, 4) == 0) begin
          // repeated header, same or one predictor step apart
          hdr = hdr ^ ($urandom_range(0, 1) ? 16'h0080 : 16'h0000);
          put_byte(hdr[15:8], ch, POS_HDR_HI);
          put_byte(hdr[7:0], ch, POS_HDR_LO);
        end
        for (int p = 0; p < nbytes; p++) begin
          if ($urandom_range(0, 15) == 0) put_byte(8'($urandom), 1'($urandom), 6'($urandom));
          put_byte(8'($urandom), ch, 6'(p) + POS_DATA);
        end
        if ($urandom_range(0, 7) == 0) wait_quiet();
      end
    end
    steady = 1'b0;
    wait_quiet();

    $display("%0d bytes fed across %0d channel-count settings, counts 0 to 3 included",
             fed, phase);
    $display("%0d samples checked, %0d of them error transfers", checked, flagged);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ima4_pkg.sv
sv/ima4_nibble_dec.sv
sv/ima4_adpcm_block_decoder.sv
sim/ima4_decoder_checker.sv
sim/tb_ima4_adpcm_block_decoder.sv
